### rtl/core/unicode_canonical_reorder_assert.svh
// Assertion macros for the canonical reorder block.
// Used by the checker; no other dependencies.
`ifndef UNICODE_CANONICAL_REORDER_ASSERT_SVH
`define UNICODE_CANONICAL_REORDER_ASSERT_SVH

// Checked property, disabled while reset is held.
`define UCR_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also active during reset.
`define UCR_ASSERT_ALW(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ucr_pkg.sv
// Shared types and constants for the canonical reorder block.
// No dependencies.
package ucr_pkg;

    localparam int CP_W = 21;
    localparam int CC_W = 8;

    localparam logic [CC_W-1:0] CC_STARTER = '0;

    // one buffered run entry
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [CC_W-1:0] cc;
    } t_entry;

endpackage

### rtl/core/unicode_canonical_reorder.sv
// Canonical reorder top level: sequencer around the run buffer memory.
// Depends on ucr_pkg and ucr_run_mem.
//
//   channel  | valid       | ready       | payload
//   ---------+-------------+-------------+---------------------------------------------
//   in       | i_in_valid  | o_in_ready  | i_code_point i_comb_class i_text_end
//   out      | o_out_valid | i_out_ready | o_out_code_point o_batch_last
//            |             |             | o_out_text_end o_run_overflow
//
// One word at a time. After it is taken, a nonstarter holds the input while it is inserted,
// directly into an empty run, else by moving past larger classes, one compare/shift per cycle.
// Each flushed word is read, loaded and handshaken in turn; a starter is sent after its run.
// Synchronous active-low reset empties the run; buffer contents are not cleared.
// A stalled output holds the sequencer; input is taken only when idle.
module unicode_canonical_reorder
    import ucr_pkg::*;
#(
    parameter int RUN_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [CP_W-1:0] i_code_point,
    input  logic [CC_W-1:0] i_comb_class,
    input  logic            i_text_end,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [CP_W-1:0] o_out_code_point,
    output logic            o_batch_last,
    output logic            o_out_text_end,
    output logic            o_run_overflow
);

    localparam int AW = $clog2(RUN_DEPTH);
    localparam int CW = $clog2(RUN_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_INS, S_CMP, S_PUT, S_FRD, S_FLD, S_FWAIT, S_START
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_p, n_p;
    logic [AW-1:0]   r_i, n_i;
    logic            r_last, n_last;
    logic            r_fl_tend, n_fl_tend;
    logic            r_fl_ovf, n_fl_ovf;
    logic            r_more, n_more;
    logic            r_inserted, n_inserted;
    logic [CP_W-1:0] r_cp, n_cp;
    logic [CC_W-1:0] r_cc, n_cc;
    logic            r_tend, n_tend;
    logic            r_out_valid, n_out_valid;
    logic [CP_W-1:0] r_out_cp, n_out_cp;
    logic            r_out_bl, n_out_bl;
    logic            r_out_tend, n_out_tend;
    logic            r_out_ovf, n_out_ovf;

    logic            mem_we, mem_re, ins_done, fl_last;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    t_entry          mem_wdata, mem_rdata;
    logic [CW-1:0]   cnt_m1;

    ucr_run_mem #(
        .DEPTH (RUN_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign cnt_m1  = r_count - CW'(1);
    assign fl_last = (CW'(r_i) + CW'(1)) == r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_p         = r_p;
        n_i         = r_i;
        n_last      = r_last;
        n_fl_tend   = r_fl_tend;
        n_fl_ovf    = r_fl_ovf;
        n_more      = r_more;
        n_inserted  = r_inserted;
        n_cp        = r_cp;
        n_cc        = r_cc;
        n_tend      = r_tend;
        n_out_valid = r_out_valid;
        n_out_cp    = r_out_cp;
        n_out_bl    = r_out_bl;
        n_out_tend  = r_out_tend;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '{cp: r_cp, cc: r_cc};
        mem_re      = 1'b0;
        mem_raddr   = '0;
        ins_done    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cp       = i_code_point;
                    n_cc       = i_comb_class;
                    n_tend     = i_text_end;
                    n_inserted = 1'b0;
                    n_i        = '0;
                    if (i_comb_class == CC_STARTER) begin
                        if (r_count != '0) begin
                            n_fl_tend = 1'b0;
                            n_fl_ovf  = 1'b0;
                            n_more    = 1'b1;
                            n_state   = S_FRD;
                        end else begin
                            n_state = S_START;
                        end
                    end else if (r_count == CW'(RUN_DEPTH)) begin
                        // full run goes out flagged before the new word starts a run
                        n_fl_tend = 1'b0;
                        n_fl_ovf  = 1'b1;
                        n_more    = i_text_end;
                        n_state   = S_FRD;
                    end else begin
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                if (r_count == '0) begin
                    mem_we   = 1'b1;
                    ins_done = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_m1[AW-1:0];
                    n_p       = r_count[AW-1:0];
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                // strict compare keeps equal classes in arrival order
                if (mem_rdata.cc > r_cc) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_p;
                    mem_wdata = mem_rdata;
                    n_p       = r_p - AW'(1);
                    if (r_p == AW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_p - AW'(2);
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_p;
                    ins_done  = 1'b1;
                end
            end
            S_PUT: begin
                mem_we   = 1'b1;
                ins_done = 1'b1;
            end
            S_FRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_i;
                n_state   = S_FLD;
            end
            S_FLD: begin
                n_out_valid = 1'b1;
                n_out_cp    = mem_rdata.cp;
                n_out_tend  = r_fl_tend && fl_last;
                n_out_ovf   = r_fl_ovf;
                n_out_bl    = fl_last && !r_more;
                n_last      = fl_last;
                n_state     = S_FWAIT;
            end
            S_FWAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_count = '0;
                        if (r_cc == CC_STARTER) begin
                            n_state = S_START;
                        end else if (!r_inserted) begin
                            n_state = S_INS;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = S_FRD;
                    end
                end
            end
            S_START: begin
                // starter word: load once, then wait for the handshake
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_cp    = r_cp;
                    n_out_tend  = r_tend;
                    n_out_bl    = 1'b1;
                    n_out_ovf   = 1'b0;
                end else if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ins_done) begin
            n_count    = r_count + CW'(1);
            n_inserted = 1'b1;
            if (r_tend) begin
                n_fl_tend = 1'b1;
                n_fl_ovf  = 1'b0;
                n_more    = 1'b0;
                n_i       = '0;
                n_state   = S_FRD;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_p        <= n_p;
        r_i        <= n_i;
        r_last     <= n_last;
        r_fl_tend  <= n_fl_tend;
        r_fl_ovf   <= n_fl_ovf;
        r_more     <= n_more;
        r_inserted <= n_inserted;
        r_cp       <= n_cp;
        r_cc       <= n_cc;
        r_tend     <= n_tend;
        r_out_cp   <= n_out_cp;
        r_out_bl   <= n_out_bl;
        r_out_tend <= n_out_tend;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_out_code_point = r_out_cp;
    assign o_batch_last     = r_out_bl;
    assign o_out_text_end   = r_out_tend;
    assign o_run_overflow   = r_out_ovf;

endmodule

### rtl/core/ucr_run_mem.sv
// Run buffer memory: one write port, one read port with registered data.
// Depends on ucr_pkg.
module ucr_run_mem
    import ucr_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ucr_check.sv
// Port-level checker for the canonical reorder block, with its bind.
// Depends on ucr_pkg and unicode_canonical_reorder_assert.svh.
`include "unicode_canonical_reorder_assert.svh"

module ucr_check
    import ucr_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [CP_W-1:0] o_out_code_point,
    input logic            o_batch_last,
    input logic            o_out_text_end
);

    `UCR_ASSERT_ALW(a_rst_idle, i_clk, !i_rst_n |=> o_in_ready && !o_out_valid, "not idle after reset")
    `UCR_ASSERT_RST(a_one_side, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "input taken while word pending")
    `UCR_ASSERT_RST(a_take_busy, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "ready held after accept")
    `UCR_ASSERT_RST(a_end_last, i_clk, i_rst_n, o_out_valid && o_out_text_end |-> o_batch_last, "text end not last of batch")
    `UCR_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_code_point), "stalled word changed")

endmodule

bind unicode_canonical_reorder ucr_check u_ucr_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_code_point (o_out_code_point),
    .o_batch_last     (o_batch_last),
    .o_out_text_end   (o_out_text_end)
);

### bench/unicode_canonical_reorder_checker.sv
// Checker for the canonical reorder block: predicts the reordered stream and scores results.
// Depends on ucr_pkg for field widths and the starter class.
module unicode_canonical_reorder_checker
    import ucr_pkg::*;
#(
    parameter int RUN_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic [CP_W-1:0] i_code_point,
    input  logic [CC_W-1:0] i_comb_class,
    input  logic            i_text_end,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  logic [CP_W-1:0] i_out_code_point,
    input  logic            i_batch_last,
    input  logic            i_out_text_end,
    input  logic            i_run_overflow,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
        logic            tend;
        logic            ovf;
    } t_ordered_word;

    // model of the run buffer
    logic [CP_W-1:0] held_cp [RUN_DEPTH];
    logic [CC_W-1:0] held_cc [RUN_DEPTH];
    int              held_n;

    t_ordered_word   ordered_q[$];   // words still owed by the block
    t_ordered_word   word_batch[$];  // words caused by the current input word
    int              n_fail;
    int              n_checked;

    initial begin
        held_n    = 0;
        n_fail    = 0;
        n_checked = 0;
        o_pending = 0;
    end

    assign o_fail_count = n_fail;
    assign o_checked    = n_checked;

    function automatic void flush_held(input logic tend_on_last, input logic ovf);
        t_ordered_word w;
        int            i;
        for (i = 0; i < held_n; i++) begin
            w.cp   = held_cp[i];
            w.last = 1'b0;
            w.tend = tend_on_last && (i == held_n - 1);
            w.ovf  = ovf;
            word_batch.push_back(w);
        end
        held_n = 0;
    endfunction

    // stable insertion: equal classes keep arrival order
    function automatic void sort_into_run(input logic [CP_W-1:0] cp, input logic [CC_W-1:0] cc);
        int p;
        p = held_n;
        if (p >= RUN_DEPTH)
            return;
        while (p > 0 && held_cc[p-1] > cc) begin
            held_cp[p] = held_cp[p-1];
            held_cc[p] = held_cc[p-1];
            p--;
        end
        held_cp[p] = cp;
        held_cc[p] = cc;
        held_n++;
    endfunction

    function automatic void predict_order(input logic [CP_W-1:0] cp, input logic [CC_W-1:0] cc,
                                          input logic te);
        t_ordered_word w;
        word_batch.delete();
        if (cc == CC_STARTER) begin
            flush_held(1'b0, 1'b0);
            w.cp   = cp;
            w.last = 1'b0;
            w.tend = te;
            w.ovf  = 1'b0;
            word_batch.push_back(w);
        end else begin
            if (held_n >= RUN_DEPTH)
                flush_held(1'b0, 1'b1);
            sort_into_run(cp, cc);
            if (te)
                flush_held(1'b1, 1'b0);
        end
        if (word_batch.size() > 0) begin
            w      = word_batch.pop_back();
            w.last = 1'b1;
            word_batch.push_back(w);
        end
        while (word_batch.size() > 0)
            ordered_q.push_back(word_batch.pop_front());
    endfunction

    function automatic void check_field(input string what, input logic [CP_W-1:0] want,
                                        input logic [CP_W-1:0] got);
        if (got !== want) begin
            n_fail++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_ordered_word want;
        if (!i_rst_n) begin
            held_n = 0;
            ordered_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_order(i_code_point, i_comb_class, i_text_end);
            if (i_out_valid && i_out_ready) begin
                n_checked++;
                if (ordered_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected word: expected none, got cp %h last %b end %b ovf %b",
                             $time, i_out_code_point, i_batch_last, i_out_text_end,
                             i_run_overflow);
                end else begin
                    want = ordered_q.pop_front();
                    check_field("code point", want.cp, i_out_code_point);
                    check_field("batch_last", CP_W'(want.last), CP_W'(i_batch_last));
                    check_field("text_end", CP_W'(want.tend), CP_W'(i_out_text_end));
                    check_field("run_overflow", CP_W'(want.ovf), CP_W'(i_run_overflow));
                end
            end
        end
        o_pending <= ordered_q.size();
    end

endmodule

### bench/unicode_canonical_reorder_tb.sv
// Top of the canonical reorder bench: clock, reset, stimulus and verdict.
// Depends on ucr_pkg, unicode_canonical_reorder and unicode_canonical_reorder_checker.
module unicode_canonical_reorder_tb
    import ucr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              RUN_DEPTH     = 16;
    localparam int              RANDOM_WORDS  = 400;
    localparam int              STALL_LIMIT   = 2000;
    localparam int              SETTLE_CYCLES = 40;
    localparam logic [CP_W-1:0] CP_MAX_SCALAR = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_ALL_ONES   = 21'h1FFFFF;
    localparam logic [CC_W-1:0] CC_MAX        = 8'd255;

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            in_valid     = 1'b0;
    logic            in_ready;
    logic [CP_W-1:0] code_point   = '0;
    logic [CC_W-1:0] comb_class   = '0;
    logic            text_end     = 1'b0;
    logic            out_valid;
    logic            out_ready    = 1'b0;
    logic [CP_W-1:0] out_code_point;
    logic            batch_last;
    logic            out_text_end;
    logic            run_overflow;

    int              fail_count;
    int              pending;
    int              checked;
    bit              no_idle      = 1'b0;
    int              n_words      = 0;
    int              n_texts      = 0;

    unicode_canonical_reorder #(.RUN_DEPTH(RUN_DEPTH)) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_code_point     (code_point),
        .i_comb_class     (comb_class),
        .i_text_end       (text_end),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_out_code_point (out_code_point),
        .o_batch_last     (batch_last),
        .o_out_text_end   (out_text_end),
        .o_run_overflow   (run_overflow)
    );

    unicode_canonical_reorder_checker #(.RUN_DEPTH(RUN_DEPTH)) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_code_point     (code_point),
        .i_comb_class     (comb_class),
        .i_text_end       (text_end),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_code_point (out_code_point),
        .i_batch_last     (batch_last),
        .i_out_text_end   (out_text_end),
        .i_run_overflow   (run_overflow),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 18);
    end

    // ends the run if neither channel moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: %0d cycles without a handshake", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_word(input logic [CP_W-1:0] cp, input logic [CC_W-1:0] cc,
                             input logic te);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 18) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        code_point <= cp;
        comb_class <= cc;
        text_end   <= te;
        do
            @(posedge clk);
        while (!in_ready);
        n_words++;
    endtask

    // hold off the sender until every owed word is out
    task automatic drain_output();
        @(negedge clk);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [CP_W-1:0] rand_cp();
        case ($urandom_range(0, 7))
            0:       return CP_W'($urandom_range(0, CP_ALL_ONES));
            1, 2, 3: return CP_W'($urandom_range(21'h300, 21'h36F));
            default: return CP_W'($urandom_range(0, CP_MAX_SCALAR));
        endcase
    endfunction

    // common marks half the time so equal classes meet often
    function automatic logic [CC_W-1:0] rand_class();
        case ($urandom_range(0, 9))
            0:       return 8'd220;
            1, 2:    return 8'd230;
            3:       return 8'd202;
            4:       return 8'd1;
            default: return CC_W'($urandom_range(1, CC_MAX));
        endcase
    endfunction

    task automatic send_text();
        int n_groups;
        int run_len;
        int g;
        int i;
        n_groups = $urandom_range(1, 4);
        for (g = 0; g < n_groups; g++) begin
            if ($urandom_range(0, 9) != 0)
                send_word(rand_cp(), CC_STARTER, 1'b0);
            if ($urandom_range(0, 14) == 0)
                run_len = $urandom_range(RUN_DEPTH - 2, 2 * RUN_DEPTH + 1);
            else
                run_len = $urandom_range(0, 4);
            for (i = 0; i < run_len; i++)
                send_word(rand_cp(), rand_class(), 1'b0);
            // noise: any class, stray end marks
            if ($urandom_range(0, 7) == 0)
                send_word(rand_cp(), CC_W'($urandom_range(0, CC_MAX)), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 1))
            send_word(rand_cp(), CC_STARTER, 1'b1);
        else
            send_word(rand_cp(), rand_class(), 1'b1);
        n_texts++;
    endtask

    initial begin
        int i;
        int n_directed;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // extremes, ties, out-of-range code points, both kinds of end mark
        send_word('0, CC_STARTER, 1'b0);
        send_word(CP_ALL_ONES, CC_MAX, 1'b0);
        send_word(CP_MAX_SCALAR, 8'd1, 1'b0);
        send_word(21'h300, 8'd230, 1'b0);
        send_word(21'h301, 8'd230, 1'b0);
        send_word(21'h41, CC_STARTER, 1'b1);
        send_word(21'h327, 8'd202, 1'b0);
        send_word(CP_ALL_ONES, 8'd1, 1'b1);
        // one past a full run, descending classes, then a lone end mark
        for (i = 0; i <= RUN_DEPTH; i++)
            send_word(CP_W'(21'h300 + i), CC_W'(240 - 10 * i), 1'b0);
        send_word(21'h345, 8'd240, 1'b1);
        drain_output();
        n_directed = n_words;
        n_texts    = 3;

        while (n_words < n_directed + RANDOM_WORDS) begin
            no_idle = (n_words >= n_directed + 150) && (n_words < n_directed + 250);
            send_text();
            if ($urandom_range(0, 9) == 0)
                drain_output();
        end
        no_idle = 1'b0;
        drain_output();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d code points in %0d texts, %0d reordered words compared,",
                 n_words, n_texts, checked);
        $display("including full-run splits, tied classes and a stretch with no stalls.");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ucr_pkg.sv
rtl/core/ucr_run_mem.sv
rtl/core/unicode_canonical_reorder.sv
rtl/core/ucr_check.sv
bench/unicode_canonical_reorder_checker.sv
bench/unicode_canonical_reorder_tb.sv
